// File: hw/rtl/swmax_pkg.sv
// Shared types and constants for the sliding window maximum block.
// Used by swmax_cell and sliding_window_maximum_core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package swmax_pkg;

    localparam int WINDOW_MAX  = 1024;
    localparam int DATA_WIDTH  = 32;
    localparam int POS_WIDTH   = 32;
    localparam int WSIZE_WIDTH = 11;

    typedef logic [WSIZE_WIDTH-1:0] t_wsize;
    typedef logic [POS_WIDTH-1:0]   t_pos;
    typedef logic signed [DATA_WIDTH-1:0] t_data;

    typedef struct packed {
        logic  valid;
        t_data value;
        t_pos  pos;
    } t_entry;

    typedef struct packed {
        logic   act;
        logic   acc;
        logic   pop;
        logic   clr;
        t_data  sample;
        t_pos   pos;
        t_wsize wsize;
    } t_ctrl;

endpackage

`default_nettype wire

// File: hw/rtl/swmax_cell.sv
// One cell of the candidate row: holds one deque entry and hands it to its neighbor.
// Depends on swmax_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swmax_cell (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  swmax_pkg::t_ctrl          i_ctrl,
    input  swmax_pkg::t_entry         i_up,
    input  wire                       i_keep_below,
    output swmax_pkg::t_entry         o_ent,
    output logic                      o_keep,
    output logic                      o_expired,
    output swmax_pkg::t_data          o_next_value
);

    swmax_pkg::t_entry r_ent;
    swmax_pkg::t_entry n_ent;
    swmax_pkg::t_entry src;
    swmax_pkg::t_pos   age;
    logic              keep;
    logic              app;

    always_comb begin
        src = i_ctrl.pop ? i_up : r_ent;
        if (i_ctrl.clr) begin
            src.valid = 1'b0;
        end
        if (i_ctrl.acc) begin
            keep = src.valid && !($signed(src.value) < $signed(i_ctrl.sample));
        end else begin
            keep = src.valid;
        end
        app = i_ctrl.acc && !keep && i_keep_below;
        n_ent = r_ent;
        if (i_ctrl.act) begin
            n_ent = src;
            n_ent.valid = keep;
            if (app) begin
                n_ent.valid = 1'b1;
                n_ent.value = i_ctrl.sample;
                n_ent.pos   = i_ctrl.pos;
            end
        end
    end

    assign age          = i_ctrl.pos - r_ent.pos;
    assign o_expired    = r_ent.valid && (age >= swmax_pkg::POS_WIDTH'(i_ctrl.wsize));
    assign o_keep       = keep;
    assign o_ent        = r_ent;
    assign o_next_value = n_ent.value;

    always_ff @(posedge i_clk) begin
        r_ent.value <= n_ent.value;
        r_ent.pos   <= n_ent.pos;
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
        end else begin
            r_ent.valid <= n_ent.valid;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/sliding_window_maximum_core.sv
// Sliding window maximum over a signed sample stream, kept as a monotonic deque in a row of cells.
// Depends on swmax_pkg and swmax_cell.
`timescale 1ns / 1ps
`default_nettype none

// The block takes at most one sample beat per cycle and returns the maximum of the last
// window_size samples (0 acts as 1, above 1024 as 1024) once that many have arrived since the
// sequence began. The candidates live in a row of 1024 cells that prune and append in parallel,
// and the row retires at most one expired front entry in the cycle that takes a sample. After
// the window size is reduced mid-sequence, a sample is therefore held off while each further
// front entry that has left the window is retired. The result sits in an output register in
// the cycle after its sample is taken. While a result waits there, the next sample is held
// off, unless the result leaves in that same cycle. There is no clearing pass after reset.
module sliding_window_maximum_core (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      i_cfg_wr_en,
    input  wire  [swmax_pkg::WSIZE_WIDTH-1:0]        i_cfg_wr_data,
    input  wire                                      i_in_valid,
    output logic                                     o_in_stall,
    input  wire  signed [swmax_pkg::DATA_WIDTH-1:0]  i_sample_value,
    input  wire                                      i_sequence_start,
    output logic                                     o_out_valid,
    input  wire                                      i_out_stall,
    output logic signed [swmax_pkg::DATA_WIDTH-1:0]  o_window_max
);

    localparam int N = swmax_pkg::WINDOW_MAX;

    swmax_pkg::t_wsize r_wsize;
    swmax_pkg::t_pos   r_sample_pos;
    logic              r_filled;
    logic              r_out_valid;
    swmax_pkg::t_data  r_out_max;

    swmax_pkg::t_wsize k_eff;
    swmax_pkg::t_pos   pos_cur;
    swmax_pkg::t_ctrl  ctrl;
    logic              out_free;
    logic              pop_only;
    logic              accept;
    logic              filled_next;

    swmax_pkg::t_entry ent     [0:N];
    logic              keep    [0:N];
    logic              expired [0:N-1];
    swmax_pkg::t_data  nval    [0:N-1];

    assign ent[N]  = '0;
    assign keep[0] = 1'b1;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cell
            swmax_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (ctrl),
                .i_up         (ent[gi+1]),
                .i_keep_below (keep[gi]),
                .o_ent        (ent[gi]),
                .o_keep       (keep[gi+1]),
                .o_expired    (expired[gi]),
                .o_next_value (nval[gi])
            );
        end
    endgenerate

    always_comb begin
        if (r_wsize == '0) begin
            k_eff = swmax_pkg::WSIZE_WIDTH'(1);
        end else if (r_wsize > swmax_pkg::WSIZE_WIDTH'(N)) begin
            k_eff = swmax_pkg::WSIZE_WIDTH'(N);
        end else begin
            k_eff = r_wsize;
        end
    end

    assign pos_cur     = i_sequence_start ? '0 : r_sample_pos;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign pop_only    = i_in_valid && !i_sequence_start && expired[0] && expired[1];
    assign accept      = i_in_valid && out_free && !pop_only;
    assign o_in_stall  = !out_free || (!i_sequence_start && expired[0] && expired[1]);
    assign filled_next = (!i_sequence_start && r_filled) ||
                         (({1'b0, pos_cur} + 33'd1) >= 33'(k_eff));

    always_comb begin
        ctrl.act    = accept || pop_only;
        ctrl.acc    = accept;
        ctrl.pop    = accept ? (!i_sequence_start && expired[0]) : pop_only;
        ctrl.clr    = accept && i_sequence_start;
        ctrl.sample = i_sample_value;
        ctrl.pos    = pos_cur;
        ctrl.wsize  = k_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsize      <= swmax_pkg::WSIZE_WIDTH'(1);
            r_sample_pos <= '0;
            r_filled     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_wsize <= i_cfg_wr_data;
            end
            if (accept) begin
                r_sample_pos <= pos_cur + swmax_pkg::POS_WIDTH'(1);
                r_filled     <= filled_next;
            end
            if (out_free) begin
                r_out_valid <= accept && filled_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && filled_next) begin
            r_out_max <= nval[0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_window_max = r_out_max;

    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ent[1].valid |-> ent[0].valid)
        else $error("Occupied cells do not form a prefix of the row.");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ent[1].valid |-> ($signed(ent[0].value) >= $signed(ent[1].value)))
        else $error("Candidate values rise from front to back.");

    a_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ent[0].valid)
        else $error("Front cell empty after a sample beat.");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_sequence_start) |=> (ent[0].valid && !ent[1].valid))
        else $error("Sequence start left stale candidates in the row.");

endmodule

`default_nettype wire
